/* sv/ppfb_pkg.sv */
// Shared types, operation codes and constants for the page-packed frame buffer.
// Used by every module of the block; depends on nothing.
package ppfb_pkg;

  // default store geometry
  localparam int MAX_WIDTH_DEFAULT = 128;
  localparam int MAX_PAGES_DEFAULT = 8;

  // store index carried from front to back: page (3 bits) * width (8 bits) + column
  localparam int IDX_W = 11;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [7:0] WIDTH_RESET  = 8'd128;
  localparam logic [6:0] HEIGHT_RESET = 7'd64;

  // operation codes
  localparam logic [2:0] OP_WRITE_PIXEL = 3'd0;
  localparam logic [2:0] OP_WRITE_BYTE  = 3'd1;
  localparam logic [2:0] OP_MASKED_BYTE = 3'd2;
  localparam logic [2:0] OP_READ_BYTE   = 3'd3;
  localparam logic [2:0] OP_OR_BITS     = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL   = 3'd5;
  localparam logic [2:0] OP_TAKE_DIRTY  = 3'd6;

  // masks of the n low bits of a byte
  localparam logic [7:0] LOW_MASKS [8] = '{
    8'h00, 8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f
  };

  // input word
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] x_pos;
    logic [7:0] y_pos;
    logic [7:0] data_byte;
    logic [7:0] mask_byte;
    logic [2:0] bit_count;
    logic       color;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
    logic [7:0] dirty_pages;
  } out_word_t;

  // geometry in use, derived from the registers
  typedef struct packed {
    logic [7:0] width;
    logic [3:0] pages;
  } geom_t;

  // classified command handed from front to back
  typedef struct packed {
    logic [2:0]       op;
    logic             off;       // refused, nothing written
    logic             has_next;  // page below the addressed one is in use
    logic [2:0]       pg;
    logic [2:0]       sh;
    logic [IDX_W-1:0] idx0;
    logic [IDX_W-1:0] idx1;
    logic [7:0]       data;
    logic [7:0]       mask;
    logic             color;
  } cmd_t;

endpackage

/* sv/ppfb_front.sv */
// Front end of the frame buffer: takes input words, checks bounds, computes store indexes.
// Depends on ppfb_pkg.
module ppfb_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  ppfb_pkg::in_word_t in_word,
  input  ppfb_pkg::geom_t   geom,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              push,
  output ppfb_pkg::cmd_t    push_word
);

  logic [4:0]                 pg_full;
  logic [2:0]                 sh;
  logic                       on_disp;
  logic                       has_next;
  logic                       unaligned_end;
  logic                       off;
  logic [ppfb_pkg::IDX_W-1:0] idx0;
  logic [ppfb_pkg::IDX_W-1:0] idx1;

  // handshake
  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;

  // position decode
  assign pg_full = in_word.y_pos[7:3];
  assign sh      = in_word.y_pos[2:0];
  assign on_disp = (in_word.x_pos < geom.width) &&
                   (in_word.y_pos < {1'b0, geom.pages, 3'b000});
  assign has_next = ({1'b0, pg_full} + 6'd1) < {2'b00, geom.pages};
  assign unaligned_end = (sh != 3'd0) && !has_next;

  // store indexes of the addressed byte and the one in the next page
  assign idx0 = ppfb_pkg::IDX_W'(pg_full[2:0]) * ppfb_pkg::IDX_W'(geom.width)
              + ppfb_pkg::IDX_W'(in_word.x_pos);
  assign idx1 = idx0 + ppfb_pkg::IDX_W'(geom.width);

  // refusal check per operation
  always_comb begin
    if (in_word.operation inside {ppfb_pkg::OP_WRITE_BYTE, ppfb_pkg::OP_MASKED_BYTE}) begin
      off = !on_disp || unaligned_end;
    end else if (in_word.operation inside {ppfb_pkg::OP_WRITE_PIXEL,
                                           ppfb_pkg::OP_READ_BYTE,
                                           ppfb_pkg::OP_OR_BITS}) begin
      off = !on_disp;
    end else begin
      off = 1'b0;
    end
  end

  // command word
  always_comb begin
    push_word.op       = in_word.operation;
    push_word.off      = off;
    push_word.has_next = has_next;
    push_word.pg       = pg_full[2:0];
    push_word.sh       = sh;
    push_word.idx0     = on_disp ? idx0 : '0;
    push_word.idx1     = (on_disp && has_next) ? idx1 : '0;
    push_word.mask     = in_word.mask_byte;
    push_word.color    = in_word.color;
    if (in_word.operation == ppfb_pkg::OP_OR_BITS) begin
      push_word.data = in_word.data_byte & ppfb_pkg::LOW_MASKS[in_word.bit_count];
    end else begin
      push_word.data = in_word.data_byte;
    end
  end

endmodule

/* sv/ppfb_queue.sv */
// Two-entry command queue between the front and back of the frame buffer.
// Depends on ppfb_pkg.
module ppfb_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppfb_pkg::cmd_t push_word,
  output logic           full,
  output logic           head_valid,
  output ppfb_pkg::cmd_t head,
  input  logic           pop
);

  localparam int PTR_W = (ppfb_pkg::QUEUE_DEPTH > 1) ? $clog2(ppfb_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(ppfb_pkg::QUEUE_DEPTH + 1);

  ppfb_pkg::cmd_t   entries [ppfb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(ppfb_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(ppfb_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(ppfb_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* sv/ppfb_back.sv */
// Back end of the frame buffer: frame store memory, dirty mask, command execution,
// clear sweeps and the result register. Depends on ppfb_pkg.
module ppfb_back #(
  parameter int MAX_WIDTH = ppfb_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_PAGES = ppfb_pkg::MAX_PAGES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  ppfb_pkg::geom_t     geom,
  input  logic                head_valid,
  input  ppfb_pkg::cmd_t      head,
  output logic                pop,
  output logic                init_busy,
  output logic                out_valid,
  input  logic                out_ready,
  output ppfb_pkg::out_word_t out_word
);

  localparam int DEPTH  = MAX_WIDTH * MAX_PAGES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WR2   = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  // frame store
  logic [7:0] mem [DEPTH];

  // registers
  state_t              state, state_next;
  ppfb_pkg::cmd_t      cmd;
  logic [7:0]          rd0, rd1;
  logic [7:0]          dirty, dirty_next;
  logic                out_valid_next;
  ppfb_pkg::out_word_t out_word_next;
  logic [ADDR_W-1:0]   sweep_addr, sweep_addr_next;
  logic [7:0]          sweep_col, sweep_col_next;
  logic [3:0]          sweep_page, sweep_page_next;
  logic                pend, pend_next;
  logic [ADDR_W-1:0]   pend_addr, pend_addr_next;
  logic [2:0]          pend_page, pend_page_next;

  // memory port controls
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [7:0]        wd;
  logic              re0, re1;
  logic [ADDR_W-1:0] ra0, ra1;

  // execution datapath
  logic [15:0] pair;
  logic [15:0] pair_shift;
  logic [7:0]  rd_val;
  logic [7:0]  low_m;
  logic [7:0]  merged;
  logic [7:0]  byte_val;
  logic [15:0] wide;
  logic [7:0]  pix_bit;
  logic [7:0]  page_bit0, page_bit1;
  logic        we0, need2;
  logic [7:0]  wd0, wd1;
  logic [7:0]  mark0, mark1;
  logic [7:0]  rdata;

  logic        slot_free;
  logic        sweep_issue;
  logic [ADDR_W-1:0] idx0_a, idx1_a;

  assign slot_free   = !out_valid || out_ready;
  assign init_busy   = (state == S_INIT);
  assign idx0_a      = cmd.idx0[ADDR_W-1:0];
  assign idx1_a      = cmd.idx1[ADDR_W-1:0];
  assign sweep_issue = (sweep_page < geom.pages) && (geom.width != 8'd0);

  // byte read at an arbitrary row, and the values an operation writes
  assign pair       = {(cmd.has_next ? rd1 : 8'h00), rd0};
  assign pair_shift = pair >> cmd.sh;
  assign rd_val     = pair_shift[7:0];
  assign low_m      = ppfb_pkg::LOW_MASKS[cmd.sh];
  assign merged     = (rd_val & ~cmd.mask) | (cmd.data & cmd.mask);
  assign byte_val   = (cmd.op == ppfb_pkg::OP_MASKED_BYTE) ? merged : cmd.data;
  assign wide       = {8'h00, byte_val} << cmd.sh;
  assign pix_bit    = 8'h01 << cmd.sh;
  assign page_bit0  = 8'h01 << cmd.pg;
  assign page_bit1  = 8'h01 << 3'(cmd.pg + 3'd1);

  always_comb begin
    we0   = 1'b0;
    wd0   = rd0;
    mark0 = 8'h00;
    need2 = 1'b0;
    wd1   = rd1;
    mark1 = 8'h00;
    rdata = 8'h00;
    if (!cmd.off) begin
      case (cmd.op)
        ppfb_pkg::OP_WRITE_PIXEL: begin
          wd0   = cmd.color ? (rd0 | pix_bit) : (rd0 & ~pix_bit);
          we0   = (wd0 != rd0);
          mark0 = we0 ? page_bit0 : 8'h00;
        end
        ppfb_pkg::OP_WRITE_BYTE, ppfb_pkg::OP_MASKED_BYTE: begin
          // aligned rows keep nothing of the old byte; unaligned rows also rewrite the next page
          wd0   = (rd0 & low_m) | wide[7:0];
          we0   = (wd0 != rd0);
          mark0 = we0 ? page_bit0 : 8'h00;
          need2 = (cmd.sh != 3'd0);
          wd1   = (rd1 & ~low_m) | wide[15:8];
          mark1 = need2 ? page_bit1 : 8'h00;
        end
        ppfb_pkg::OP_READ_BYTE: begin
          rdata = rd_val;
        end
        ppfb_pkg::OP_OR_BITS: begin
          wd0   = rd0 | wide[7:0];
          we0   = (wide[7:0] != 8'h00);
          mark0 = we0 ? page_bit0 : 8'h00;
          need2 = (wide[15:8] != 8'h00) && cmd.has_next;
          wd1   = rd1 | wide[15:8];
          mark1 = need2 ? page_bit1 : 8'h00;
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_next      = state;
    dirty_next      = dirty;
    out_valid_next  = out_valid && !out_ready;
    out_word_next   = out_word;
    sweep_addr_next = sweep_addr;
    sweep_col_next  = sweep_col;
    sweep_page_next = sweep_page;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    pend_page_next  = pend_page;
    pop = 1'b0;
    we  = 1'b0;
    wa  = sweep_addr;
    wd  = 8'h00;
    re0 = 1'b0;
    re1 = 1'b0;
    ra0 = idx0_a;
    ra1 = idx1_a;
    case (state)
      S_INIT: begin
        // zero the whole store after reset
        we = 1'b1;
        wa = sweep_addr;
        if (sweep_addr == LAST_ADDR) begin
          sweep_addr_next = '0;
          state_next      = S_IDLE;
        end else begin
          sweep_addr_next = sweep_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          re0        = 1'b1;
          re1        = 1'b1;
          ra0        = head.idx0[ADDR_W-1:0];
          ra1        = head.idx1[ADDR_W-1:0];
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd.op)
          ppfb_pkg::OP_CLEAR_ALL: begin
            sweep_addr_next = '0;
            sweep_col_next  = 8'd0;
            sweep_page_next = 4'd0;
            pend_next       = 1'b0;
            state_next      = S_CLEAR;
          end
          ppfb_pkg::OP_TAKE_DIRTY: begin
            if (slot_free) begin
              out_valid_next = 1'b1;
              out_word_next  = '{read_data: 8'h00, status: 1'b0, dirty_pages: dirty};
              dirty_next     = 8'h00;
              state_next     = S_IDLE;
            end
          end
          default: begin
            wa = idx0_a;
            wd = wd0;
            if (need2) begin
              we         = we0;
              dirty_next = dirty | mark0;
              state_next = S_WR2;
            end else if (slot_free) begin
              we             = we0;
              dirty_next     = dirty | mark0;
              out_valid_next = 1'b1;
              out_word_next  = '{read_data: rdata, status: cmd.off,
                                 dirty_pages: dirty | mark0};
              state_next     = S_IDLE;
            end
          end
        endcase
      end
      S_WR2: begin
        // second store byte of an unaligned write or a spilling or
        wa = idx1_a;
        wd = wd1;
        if (slot_free) begin
          we             = 1'b1;
          dirty_next     = dirty | mark1;
          out_valid_next = 1'b1;
          out_word_next  = '{read_data: rdata, status: cmd.off,
                             dirty_pages: dirty | mark1};
          state_next     = S_IDLE;
        end
      end
      S_CLEAR: begin
        // read one byte a cycle, zero it the next cycle if it held anything
        ra0 = sweep_addr;
        if (sweep_issue) begin
          re0             = 1'b1;
          pend_next       = 1'b1;
          pend_addr_next  = sweep_addr;
          pend_page_next  = sweep_page[2:0];
          sweep_addr_next = sweep_addr + 1'b1;
          if (sweep_col == geom.width - 8'd1) begin
            sweep_col_next  = 8'd0;
            sweep_page_next = sweep_page + 4'd1;
          end else begin
            sweep_col_next = sweep_col + 8'd1;
          end
        end else begin
          pend_next = 1'b0;
        end
        wa = pend_addr;
        wd = 8'h00;
        if (pend && (rd0 != 8'h00)) begin
          we         = 1'b1;
          dirty_next = dirty | (8'h01 << pend_page);
        end
        if (!sweep_issue && !pend && slot_free) begin
          out_valid_next = 1'b1;
          out_word_next  = '{read_data: 8'h00, status: 1'b0, dirty_pages: dirty};
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // store write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re0) begin
      rd0 <= mem[ra0];
    end
    if (re1) begin
      rd1 <= mem[ra1];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    out_word  <= out_word_next;
    sweep_col <= sweep_col_next;
    pend_addr <= pend_addr_next;
    pend_page <= pend_page_next;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      dirty      <= 8'h00;
      out_valid  <= 1'b0;
      sweep_addr <= '0;
      sweep_page <= 4'd0;
      pend       <= 1'b0;
    end else begin
      state      <= state_next;
      dirty      <= dirty_next;
      out_valid  <= out_valid_next;
      sweep_addr <= sweep_addr_next;
      sweep_page <= sweep_page_next;
      pend       <= pend_next;
    end
  end

endmodule

/* sv/page_packed_frame_buffer.sv */
// Page-packed monochrome frame buffer with per-page dirty bits. After reset the store is
// zeroed one byte a cycle, MAX_WIDTH*MAX_PAGES bytes, during which in_ready stays low
// (register writes still work). Input words are classified and queued two deep; the back
// end pops one word, reads the store (two read ports, registered) and executes, so most
// operations finish in the execute state, while unaligned byte writes and or-bits spilling
// into the next page also pass through a second write state, bound by the single store
// write port. Clear all walks width*pages bytes at one a cycle. Each operation returns
// exactly one result word. Depends on ppfb_pkg, ppfb_front, ppfb_queue and ppfb_back.
module page_packed_frame_buffer #(
  parameter int MAX_WIDTH = ppfb_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_PAGES = ppfb_pkg::MAX_PAGES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ppfb_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output ppfb_pkg::out_word_t out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  logic [7:0]       width_reg;
  logic [6:0]       height_reg;
  logic [3:0]       height_pages;
  ppfb_pkg::geom_t  geom;
  logic             q_full;
  logic             push;
  ppfb_pkg::cmd_t   push_word;
  logic             head_valid;
  ppfb_pkg::cmd_t   head;
  logic             pop;
  logic             init_busy;

  // register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= ppfb_pkg::WIDTH_RESET;
      height_reg <= ppfb_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_WIDTH:  width_reg  <= pwdata[7:0];
        REG_HEIGHT: height_reg <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {24'h000000, width_reg};
      REG_HEIGHT: prdata = {25'h0000000, height_reg};
      default:    prdata = 32'h00000000;
    endcase
  end

  // geometry in use, capped to the store size
  assign height_pages = height_reg[6:3];
  assign geom.width   = ({1'b0, width_reg} > 9'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : width_reg;
  assign geom.pages   = (height_pages > 4'(MAX_PAGES)) ? 4'(MAX_PAGES) : height_pages;

  ppfb_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .geom      (geom),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_word (push_word)
  );

  ppfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  ppfb_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PAGES (MAX_PAGES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .geom       (geom),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .init_busy  (init_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

endmodule

/* bench/page_packed_frame_buffer_test.sv */
// Self-checking bench for the page-packed frame buffer: drives op words, predicts every
// result word from a private model of the frame store and dirty bits, and checks them in order.
// Depends on ppfb_pkg and page_packed_frame_buffer.
module page_packed_frame_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS_MAX     = ppfb_pkg::MAX_WIDTH_DEFAULT;
  localparam int PAGES_MAX    = ppfb_pkg::MAX_PAGES_DEFAULT;
  localparam int STORE_BYTES  = COLS_MAX * PAGES_MAX;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 16;

  // code the block leaves unused
  localparam logic [2:0] OP_UNUSED = 3'd7;

  // register byte addresses
  localparam logic [2:0] ADDR_WIDTH  = 3'd0;
  localparam logic [2:0] ADDR_HEIGHT = 3'd4;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ppfb_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ppfb_pkg::out_word_t out_word;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  page_packed_frame_buffer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  // shadow of the frame store, dirty bits and geometry registers
  logic [7:0] frame_img [STORE_BYTES];
  logic [7:0] dirty_bits = '0;
  logic [7:0] width_reg  = ppfb_pkg::WIDTH_RESET;
  logic [6:0] height_reg = ppfb_pkg::HEIGHT_RESET;

  ppfb_pkg::out_word_t frame_results_q [$];
  int        fail_count    = 0;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        hot_x = 0;
  int        hot_y = 0;

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) frame_img[i] = 8'h00;
  end

  // geometry in use
  function automatic int unsigned used_width();
    return (width_reg > COLS_MAX) ? COLS_MAX : width_reg;
  endfunction

  function automatic int unsigned used_pages();
    int unsigned p;
    p = height_reg >> 3;
    return (p > PAGES_MAX) ? PAGES_MAX : p;
  endfunction

  function automatic int unsigned store_index(input int unsigned pg, input int unsigned x);
    return (pg * used_width() + x) % STORE_BYTES;
  endfunction

  function automatic bit on_screen(input int unsigned x, input int unsigned y);
    return (x < used_width()) && (y < used_pages() * 8);
  endfunction

  // eight pixels starting at row y, zeros past the last page
  function automatic logic [7:0] peek_byte(input int unsigned x, input int unsigned y);
    int unsigned pg, sh, lo, hi;
    pg = y >> 3;
    sh = y & 7;
    lo = frame_img[store_index(pg, x)];
    lo = lo >> sh;
    if (sh != 0 && pg + 1 < used_pages()) begin
      hi = frame_img[store_index(pg + 1, x)];
      lo = lo | (hi << (8 - sh));
    end
    return lo[7:0];
  endfunction

  // byte write at any row, returns the refusal flag
  function automatic logic put_byte(input int unsigned x, input int unsigned y,
                                    input int unsigned b);
    int unsigned pg, sh, i0, i1, w, keep, lo, hi;
    pg = y >> 3;
    sh = y & 7;
    if (!on_screen(x, y)) return 1'b1;
    i0 = store_index(pg, x);
    if (sh != 0) begin
      if (pg + 1 >= used_pages()) return 1'b1;
      i1 = store_index(pg + 1, x);
      // lower page is always marked on an unaligned write
      dirty_bits[pg + 1] = 1'b1;
      w    = b << sh;
      keep = ~(32'hff << sh) & 32'hffff;
      lo   = (frame_img[i0] & keep & 32'hff) | (w & 32'hff);
      if (lo != frame_img[i0]) begin
        frame_img[i0] = lo[7:0];
        dirty_bits[pg] = 1'b1;
      end
      hi = (frame_img[i1] & (keep >> 8)) | (w >> 8);
      frame_img[i1] = hi[7:0];
      return 1'b0;
    end
    // aligned part rewrites only on change
    if (frame_img[i0] != b[7:0]) begin
      frame_img[i0] = b[7:0];
      dirty_bits[pg] = 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one op word to the shadow store and give the result word it owes
  function automatic ppfb_pkg::out_word_t run_frame_op(input ppfb_pkg::in_word_t w);
    ppfb_pkg::out_word_t r;
    int unsigned x, y, pg, sh, i, v, low, bits, lo, hi;
    logic [7:0]  merged;
    logic        any_set;
    x  = w.x_pos;
    y  = w.y_pos;
    pg = y >> 3;
    sh = y & 7;
    r  = '0;
    case (w.operation)
      ppfb_pkg::OP_WRITE_PIXEL: begin
        if (!on_screen(x, y)) begin
          r.status = 1'b1;
        end else begin
          i = store_index(pg, x);
          v = frame_img[i];
          if (w.color) v = v | (1 << sh);
          else v = v & ~(1 << sh) & 32'hff;
          if (v != frame_img[i]) begin
            frame_img[i] = v[7:0];
            dirty_bits[pg] = 1'b1;
          end
        end
      end
      ppfb_pkg::OP_WRITE_BYTE: r.status = put_byte(x, y, w.data_byte);
      ppfb_pkg::OP_MASKED_BYTE: begin
        if (!on_screen(x, y)) begin
          r.status = 1'b1;
        end else begin
          merged = (peek_byte(x, y) & ~w.mask_byte) | (w.data_byte & w.mask_byte);
          r.status = put_byte(x, y, merged);
        end
      end
      ppfb_pkg::OP_READ_BYTE: begin
        if (!on_screen(x, y)) r.status = 1'b1;
        else r.read_data = peek_byte(x, y);
      end
      ppfb_pkg::OP_OR_BITS: begin
        if (!on_screen(x, y)) begin
          r.status = 1'b1;
        end else begin
          low  = (1 << w.bit_count) - 1;
          bits = (w.data_byte & low) << sh;
          lo   = bits & 32'hff;
          hi   = bits >> 8;
          if (lo != 0) begin
            i = store_index(pg, x);
            frame_img[i] = frame_img[i] | lo[7:0];
            dirty_bits[pg] = 1'b1;
          end
          // spill past the last page is dropped
          if (hi != 0 && pg + 1 < used_pages()) begin
            i = store_index(pg + 1, x);
            frame_img[i] = frame_img[i] | hi[7:0];
            dirty_bits[pg + 1] = 1'b1;
          end
        end
      end
      ppfb_pkg::OP_CLEAR_ALL: begin
        // only pages that held something get marked
        for (int unsigned p = 0; p < used_pages(); p++) begin
          any_set = 1'b0;
          for (int unsigned c = 0; c < used_width(); c++) begin
            i = store_index(p, c);
            if (frame_img[i] != 8'h00) begin
              any_set = 1'b1;
              frame_img[i] = 8'h00;
            end
          end
          if (any_set) dirty_bits[p] = 1'b1;
        end
      end
      ppfb_pkg::OP_TAKE_DIRTY: begin
        r.dirty_pages = dirty_bits;
        dirty_bits = '0;
        return r;
      end
      default: ;
    endcase
    r.dirty_pages = dirty_bits;
    return r;
  endfunction

  function automatic ppfb_pkg::in_word_t word_of(input logic [2:0] op, input logic [7:0] x,
                                                 input logic [7:0] y, input logic [7:0] data,
                                                 input logic [7:0] mask,
                                                 input logic [2:0] count,
                                                 input logic color);
    ppfb_pkg::in_word_t w;
    w.operation = op;
    w.x_pos     = x;
    w.y_pos     = y;
    w.data_byte = data;
    w.mask_byte = mask;
    w.bit_count = count;
    w.color     = color;
    return w;
  endfunction

  // random op word, mostly on display and often around a hot spot
  function automatic ppfb_pkg::in_word_t random_word();
    ppfb_pkg::in_word_t w;
    int unsigned pick, cols, rows;
    cols = used_width();
    rows = used_pages() * 8;
    pick = $urandom_range(99);
    if (pick < 20) w.operation = ppfb_pkg::OP_WRITE_PIXEL;
    else if (pick < 40) w.operation = ppfb_pkg::OP_WRITE_BYTE;
    else if (pick < 55) w.operation = ppfb_pkg::OP_MASKED_BYTE;
    else if (pick < 73) w.operation = ppfb_pkg::OP_READ_BYTE;
    else if (pick < 88) w.operation = ppfb_pkg::OP_OR_BITS;
    else if (pick < 90) w.operation = ppfb_pkg::OP_CLEAR_ALL;
    else if (pick < 97) w.operation = ppfb_pkg::OP_TAKE_DIRTY;
    else w.operation = OP_UNUSED;
    pick = $urandom_range(99);
    if (pick < 12) begin
      w.x_pos = 8'($urandom_range(255));
      w.y_pos = 8'($urandom_range(255));
    end else if (pick < 45) begin
      w.x_pos = 8'(hot_x);
      w.y_pos = 8'((hot_y & ~7) + $urandom_range(7));
    end else begin
      w.x_pos = 8'($urandom_range(cols - 1));
      w.y_pos = 8'($urandom_range(rows - 1));
    end
    if ($urandom_range(9) == 0) begin
      hot_x = $urandom_range(cols - 1);
      hot_y = $urandom_range(rows - 1);
    end
    w.data_byte = 8'($urandom_range(255));
    w.mask_byte = 8'($urandom_range(255));
    w.bit_count = 3'($urandom_range(7));
    w.color     = 1'($urandom_range(1));
    return w;
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker against the oldest predicted word
  always @(posedge clk) begin
    ppfb_pkg::out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        $error("result word with none outstanding: %h", out_word);
        fail_count++;
      end else begin
        want = frame_results_q.pop_front();
        if (out_word.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_word.read_data);
          fail_count++;
        end
        if (out_word.status !== want.status) begin
          $error("status: expected %h, got %h", want.status, out_word.status);
          fail_count++;
        end
        if (out_word.dirty_pages !== want.dirty_pages) begin
          $error("dirty_pages: expected %h, got %h", want.dirty_pages, out_word.dirty_pages);
          fail_count++;
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("page_packed_frame_buffer test failed");
      $finish;
    end
  end

  // send one op word, valid held until accepted
  task automatic send_word(input ppfb_pkg::in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    frame_results_q.push_back(run_frame_op(w));
  endtask

  // stop sending and wait until every result word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register access: setup phase, then access phase, then psel and penable dropped
  task automatic access_reg(input logic write, input logic [2:0] addr,
                            input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= write ? value : 32'h0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (write) begin
      if (addr == ADDR_WIDTH) width_reg = value[7:0];
      else if (addr == ADDR_HEIGHT) height_reg = value[6:0];
    end else if (prdata !== value) begin
      $error("prdata at %h: expected %h, got %h", addr, value, prdata);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // new geometry, read back
  task automatic set_geometry(input logic [7:0] cols, input logic [6:0] rows);
    access_reg(1'b1, ADDR_WIDTH, {24'h0, cols});
    access_reg(1'b1, ADDR_HEIGHT, {25'h0, rows});
    access_reg(1'b0, ADDR_WIDTH, {24'h0, cols});
    access_reg(1'b0, ADDR_HEIGHT, {25'h0, rows});
    hot_x = 0;
    hot_y = 0;
  endtask

  task automatic run_random(input int count);
    for (int n = 0; n < count; n++) send_word(random_word());
  endtask

  // every op and edge case at the reset geometry
  task automatic test_directed_ops();
    access_reg(1'b0, ADDR_WIDTH, {24'h0, ppfb_pkg::WIDTH_RESET});
    access_reg(1'b0, ADDR_HEIGHT, {25'h0, ppfb_pkg::HEIGHT_RESET});
    send_word(word_of(ppfb_pkg::OP_WRITE_PIXEL, 0, 0, 0, 0, 0, 1));
    send_word(word_of(ppfb_pkg::OP_WRITE_PIXEL, 127, 63, 0, 0, 0, 1));
    send_word(word_of(ppfb_pkg::OP_WRITE_PIXEL, 127, 63, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_WRITE_PIXEL, 128, 0, 0, 0, 0, 1));
    send_word(word_of(ppfb_pkg::OP_WRITE_PIXEL, 0, 64, 0, 0, 0, 1));
    send_word(word_of(ppfb_pkg::OP_TAKE_DIRTY, 0, 0, 0, 0, 0, 0));
    // aligned byte, then the same byte again leaves the page clean
    send_word(word_of(ppfb_pkg::OP_WRITE_BYTE, 5, 8, 8'hff, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_TAKE_DIRTY, 0, 0, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_WRITE_BYTE, 5, 8, 8'hff, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_WRITE_BYTE, 5, 11, 8'ha5, 0, 0, 0));
    // unaligned in the last page is refused
    send_word(word_of(ppfb_pkg::OP_WRITE_BYTE, 6, 59, 8'hff, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_WRITE_BYTE, 6, 56, 8'h81, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_MASKED_BYTE, 5, 11, 8'h0f, 8'h3c, 0, 0));
    send_word(word_of(ppfb_pkg::OP_MASKED_BYTE, 255, 255, 8'hff, 8'hff, 7, 1));
    send_word(word_of(ppfb_pkg::OP_READ_BYTE, 5, 8, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_READ_BYTE, 5, 11, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_READ_BYTE, 6, 60, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_READ_BYTE, 128, 5, 0, 0, 0, 0));
    // zero count ors nothing, full count spills, spill past last page dropped
    send_word(word_of(ppfb_pkg::OP_OR_BITS, 9, 3, 8'hff, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_OR_BITS, 9, 5, 8'h7f, 0, 7, 0));
    send_word(word_of(ppfb_pkg::OP_OR_BITS, 10, 61, 8'hff, 0, 7, 0));
    send_word(word_of(ppfb_pkg::OP_TAKE_DIRTY, 0, 0, 0, 0, 0, 0));
    send_word(word_of(OP_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 7, 1));
    send_word(word_of(ppfb_pkg::OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_TAKE_DIRTY, 0, 0, 0, 0, 0, 0));
    // clear of an empty display marks nothing
    send_word(word_of(ppfb_pkg::OP_CLEAR_ALL, 0, 0, 0, 0, 0, 0));
    send_word(word_of(ppfb_pkg::OP_TAKE_DIRTY, 0, 0, 0, 0, 0, 0));
    drain_results();
  endtask

  // one column, one page
  task automatic test_narrow_display();
    set_geometry(8'd1, 7'd8);
    run_random(40);
    drain_results();
  endtask

  // odd width, height not a multiple of eight
  task automatic test_odd_geometry();
    set_geometry(8'd37, 7'd60);
    run_random(40);
    drain_results();
  endtask

  task automatic test_random_no_idle();
    set_geometry(8'd128, 7'd64);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random(170);
    drain_results();
  endtask

  task automatic test_random_sender_idle();
    set_geometry(8'd100, 7'd40);
    send_idle_pct = 58;
    stall_pct     = 0;
    run_random(170);
    drain_results();
  endtask

  task automatic test_random_receiver_stall();
    set_geometry(8'd64, 7'd16);
    send_idle_pct = 0;
    stall_pct     = 58;
    run_random(170);
    drain_results();
  endtask

  task automatic test_random_both_idle();
    set_geometry(8'd128, 7'd64);
    send_idle_pct = 25;
    stall_pct     = 25;
    run_random(170);
    drain_results();
  endtask

  // test sequence
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_ops();
    test_narrow_display();
    test_odd_geometry();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    drain_results();
    if (fail_count == 0) begin
      $display("page_packed_frame_buffer test passed");
    end else begin
      $display("page_packed_frame_buffer test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/ppfb_pkg.sv
sv/ppfb_front.sv
sv/ppfb_queue.sv
sv/ppfb_back.sv
sv/page_packed_frame_buffer.sv
bench/page_packed_frame_buffer_test.sv
